/* design/lzhc_pkg.sv */
// ----------------------------------------------------------------------------
// lzhc_pkg
// Shared types and constants for the LZ77 hash-chain lazy matcher.
// ----------------------------------------------------------------------------
package lzhc_pkg;

    // input op codes
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_MATCH   = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    // configuration register indexes
    localparam logic REG_MAX_CHAIN  = 1'b0;
    localparam logic REG_NICE_MATCH = 1'b1;

    localparam int CFG_W        = 11;
    localparam int MAX_CHAIN_W  = 11;
    localparam int NICE_MATCH_W = 9;
    localparam int LEN_W        = 9;
    localparam int DIST_W       = 16;

    localparam logic [10:0] MAX_CHAIN_RST  = 11'd160;
    localparam logic [8:0]  NICE_MATCH_RST = 9'd128;

    localparam logic [31:0] EMPTY_MARK  = 32'hFFFF_FFFF;
    localparam logic [31:0] BYTES_LIMIT = 32'hFFFF_FFFE;
    localparam logic [31:0] MIN_LEN     = 32'd3;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic       is_end;
        logic [7:0] data_byte;
    } lzhc_cmd_t;

    typedef struct packed {
        logic clearing;
    } lzhc_status_t;

endpackage

/* design/lz77_hash_chain_lazy_matcher_top.sv */
// ----------------------------------------------------------------------------
// lz77_hash_chain_lazy_matcher_top
// LZ77 token stage: hash-chain match search with one-step lazy matching.
// ----------------------------------------------------------------------------
// Each data beat is queued and then appended to the history ring; a
// token is produced once LOOKAHEAD bytes past the coding position are held,
// and each end beat yields the next pending token or the end marker. Token
// time is set by the match engine: a hash lookup steps through HASH0,
// HASH1, HASH2 and HEAD, each chain candidate passes CAND, then CMP once
// per compared byte, then LINK, a lazy check adds an index update and a
// second search, and a match adds a hash lookup for each position of its
// length that it indexes. After reset the hash head table is swept to empty
// with s_tready low; the configuration port is live throughout.
module lz77_hash_chain_lazy_matcher_top #(
    parameter int WINDOW_SIZE   = 32768,
    parameter int HASH_BITS     = 15,
    parameter int MAX_MATCH     = 258,
    parameter int LOOKAHEAD     = 262,
    parameter int HISTORY_DEPTH = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [8:0] value, [24:9] distance
    output logic [1:0]  m_tuser,    // [1:0] kind
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [lzhc_pkg::CFG_W-1:0] cfg_wdata
);
    import lzhc_pkg::*;

    logic [MAX_CHAIN_W-1:0]  max_chain_reg;
    logic [NICE_MATCH_W-1:0] nice_match_reg;

    lzhc_status_t status;
    lzhc_cmd_t    push_data, pop_data;
    logic         q_push, q_pop, q_full, q_empty;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_chain_reg  <= MAX_CHAIN_RST;
            nice_match_reg <= NICE_MATCH_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MAX_CHAIN:  max_chain_reg  <= cfg_wdata[MAX_CHAIN_W-1:0];
                REG_NICE_MATCH: nice_match_reg <= cfg_wdata[NICE_MATCH_W-1:0];
                default: ;
            endcase
        end
    end

    lzhc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .status   (status),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    lzhc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    lzhc_back #(
        .WINDOW_SIZE   (WINDOW_SIZE),
        .HASH_BITS     (HASH_BITS),
        .MAX_MATCH     (MAX_MATCH),
        .LOOKAHEAD     (LOOKAHEAD),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_data     (pop_data),
        .q_pop      (q_pop),
        .status     (status),
        .max_chain  (max_chain_reg),
        .nice_match (nice_match_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

/* design/lzhc_queue.sv */
// ----------------------------------------------------------------------------
// lzhc_queue
// Small FIFO of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module lzhc_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  lzhc_pkg::lzhc_cmd_t push_data,
    input  logic               pop,
    output lzhc_pkg::lzhc_cmd_t pop_data,
    output logic               full,
    output logic               empty
);
    import lzhc_pkg::*;

    lzhc_cmd_t           mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop && !empty) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if ((push && !full) && !(pop && !empty)) begin
            count_next = count_reg + 1'b1;
        end else if (!(push && !full) && (pop && !empty)) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/lzhc_front.sv */
// ----------------------------------------------------------------------------
// lzhc_front
// Accepts input beats, drops data after end or past the length limit and
// queues the rest as append or end commands.
// ----------------------------------------------------------------------------
module lzhc_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    input  logic                   s_tuser,   // [0] op
    input  lzhc_pkg::lzhc_status_t status,
    input  logic                   q_full,
    output logic                   q_push,
    output lzhc_pkg::lzhc_cmd_t    q_data
);
    import lzhc_pkg::*;

    logic [31:0] bytes_reg, bytes_next;
    logic        ended_reg, ended_next;
    logic        beat;

    assign s_tready = !q_full && !status.clearing;
    assign beat     = s_tvalid && s_tready;

    // classify the beat
    always_comb begin
        bytes_next       = bytes_reg;
        ended_next       = ended_reg;
        q_push           = 1'b0;
        q_data.is_end    = (s_tuser == OP_END);
        q_data.data_byte = s_tdata;
        if (beat) begin
            if (s_tuser == OP_END) begin
                ended_next = 1'b1;
                q_push     = 1'b1;
            end else if (!ended_reg && bytes_reg < BYTES_LIMIT) begin
                bytes_next = bytes_reg + 32'd1;
                q_push     = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_reg <= '0;
            ended_reg <= 1'b0;
        end else begin
            bytes_reg <= bytes_next;
            ended_reg <= ended_next;
        end
    end

endmodule

/* design/lzhc_back.sv */
// ----------------------------------------------------------------------------
// lzhc_back
// Match engine: history ring, hash heads and chain links, chain walk with
// one-step lazy evaluation, position indexing and the result register.
// ----------------------------------------------------------------------------
module lzhc_back #(
    parameter int WINDOW_SIZE   = 32768,
    parameter int HASH_BITS     = 15,
    parameter int MAX_MATCH     = 258,
    parameter int LOOKAHEAD     = 262,
    parameter int HISTORY_DEPTH = 65536
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_empty,
    input  lzhc_pkg::lzhc_cmd_t    q_data,
    output logic                   q_pop,
    output lzhc_pkg::lzhc_status_t status,
    input  logic [10:0]            max_chain,
    input  logic [8:0]             nice_match,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,   // [8:0] value, [24:9] distance
    output logic [1:0]             m_tuser    // [1:0] kind
);
    import lzhc_pkg::*;

    localparam int RING_AW = $clog2(HISTORY_DEPTH);
    localparam int WIN_AW  = $clog2(WINDOW_SIZE);
    localparam int HCOUNT  = 1 << HASH_BITS;

    localparam logic [31:0] WIN32  = 32'(WINDOW_SIZE);
    localparam logic [31:0] MAX32  = 32'(MAX_MATCH);
    localparam logic [31:0] LOOK32 = 32'(LOOKAHEAD);

    // sequencer states
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_START  = 4'd2;
    localparam logic [3:0] S_HASH0  = 4'd3;
    localparam logic [3:0] S_HASH1  = 4'd4;
    localparam logic [3:0] S_HASH2  = 4'd5;
    localparam logic [3:0] S_HEAD   = 4'd6;
    localparam logic [3:0] S_CAND   = 4'd7;
    localparam logic [3:0] S_CMP    = 4'd8;
    localparam logic [3:0] S_LINK   = 4'd9;
    localparam logic [3:0] S_SDONE  = 4'd10;
    localparam logic [3:0] S_IXL    = 4'd11;
    localparam logic [3:0] S_LIT_RD = 4'd12;
    localparam logic [3:0] S_LIT    = 4'd13;
    localparam logic [3:0] S_EMIT   = 4'd14;

    // what the hash lookup is for
    localparam logic [2:0] P_SEARCH1  = 3'd0;
    localparam logic [2:0] P_SEARCH2  = 3'd1;
    localparam logic [2:0] P_IDX_LAZY = 3'd2;
    localparam logic [2:0] P_IDX_LOOP = 3'd3;
    localparam logic [2:0] P_IDX_LIT  = 3'd4;

    // memories
    logic [7:0]  ring_mem  [HISTORY_DEPTH];
    logic [31:0] heads_mem [HCOUNT];
    logic [31:0] links_mem [WINDOW_SIZE];

    logic [7:0]  ring_qa, ring_qb;
    logic [31:0] heads_q, link_q;

    logic [31:0] ring_ra, ring_rb;
    logic        ring_we;
    logic [HASH_BITS-1:0] heads_ra, heads_wa;
    logic        heads_we, links_we;
    logic [31:0] heads_wd;

    // control registers
    logic [3:0]  state_reg, state_next;
    logic [2:0]  phase_reg, phase_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] cur_reg, cur_next;
    logic [31:0] hp_reg, hp_next;
    logic [7:0]  b0_reg, b0_next, b1_reg, b1_next;
    logic [HASH_BITS-1:0] h_reg, h_next;
    logic [HASH_BITS-1:0] clr_reg, clr_next;
    logic [31:0] s_pos_reg, s_pos_next;
    logic [8:0]  s_lim_reg, s_lim_next;
    logic [8:0]  s_best_reg, s_best_next;
    logic [15:0] s_dist_reg, s_dist_next;
    logic [10:0] s_left_reg, s_left_next;
    logic [31:0] s_cand_reg, s_cand_next;
    logic [8:0]  s_l_reg, s_l_next;
    logic [8:0]  m_best_reg, m_best_next;
    logic [15:0] m_dist_reg, m_dist_next;
    logic        indexed_reg, indexed_next;
    logic [8:0]  k_reg, k_next;
    logic [1:0]  pend_kind_reg, pend_kind_next;
    logic [8:0]  pend_value_reg, pend_value_next;
    logic [15:0] pend_dist_reg, pend_dist_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg;
    logic [8:0]  out_value_reg;
    logic [15:0] out_dist_reg;
    logic        out_load;

    // derived values
    logic [31:0] avail, avail_m1, p_ix, cand_diff;
    logic [8:0]  limit, nlim, cmp_l1, fin_l, fb;
    logic [15:0] fd;
    logic [17:0] hx;
    logic [HASH_BITS-1:0] h_comb;
    logic        cmp_eq;

    assign avail     = size_reg - cur_reg;
    assign avail_m1  = avail - 32'd1;
    assign limit     = (avail < MAX32) ? avail[8:0] : MAX32[8:0];
    assign nlim      = (avail_m1 < MAX32) ? avail_m1[8:0] : MAX32[8:0];
    assign p_ix      = cur_reg + {23'd0, k_reg};
    assign cand_diff = s_pos_reg - s_cand_reg;
    assign hx        = ({10'd0, b0_reg} << 10) ^ ({10'd0, b1_reg} << 5) ^ {10'd0, ring_qa};
    assign h_comb    = hx[HASH_BITS-1:0];
    assign cmp_eq    = (ring_qa == ring_qb);
    assign cmp_l1    = s_l_reg + 9'd1;
    assign fin_l     = (cmp_eq) ? cmp_l1 : s_l_reg;
    assign fb        = ({23'd0, s_best_reg} < MIN_LEN) ? 9'd0 : s_best_reg;
    assign fd        = ({23'd0, s_best_reg} < MIN_LEN) ? 16'd0 : s_dist_reg;

    assign status.clearing = (state_reg == S_CLEAR);
    assign out_load        = (state_reg == S_EMIT) && (!out_valid_reg || m_tready);

    // memory addresses
    always_comb begin
        ring_ra = cur_reg;
        ring_rb = cur_reg;
        case (state_reg)
            S_HASH0: begin
                ring_ra = hp_reg;
                ring_rb = hp_reg + 32'd1;
            end
            S_HASH1: begin
                ring_ra = hp_reg + 32'd2;
            end
            S_CAND: begin
                ring_ra = s_cand_reg;
                ring_rb = s_pos_reg;
            end
            S_CMP: begin
                ring_ra = s_cand_reg + {23'd0, cmp_l1};
                ring_rb = s_pos_reg + {23'd0, cmp_l1};
            end
            default: begin
                ring_ra = cur_reg;
                ring_rb = cur_reg;
            end
        endcase
    end

    assign ring_we  = (state_reg == S_IDLE) && !q_empty && !q_data.is_end;
    assign heads_ra = (state_reg == S_HASH2) ? h_comb : h_reg;
    assign links_we = (state_reg == S_HEAD) && (phase_reg != P_SEARCH1)
                      && (phase_reg != P_SEARCH2);
    assign heads_we = (state_reg == S_CLEAR) || links_we;
    assign heads_wa = (state_reg == S_CLEAR) ? clr_reg : h_reg;
    assign heads_wd = (state_reg == S_CLEAR) ? EMPTY_MARK : hp_reg;

    // history ring
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[size_reg[RING_AW-1:0]] <= q_data.data_byte;
        end
        ring_qa <= ring_mem[ring_ra[RING_AW-1:0]];
        ring_qb <= ring_mem[ring_rb[RING_AW-1:0]];
    end

    // hash head table
    always_ff @(posedge aclk) begin
        if (heads_we) begin
            heads_mem[heads_wa] <= heads_wd;
        end
        heads_q <= heads_mem[heads_ra];
    end

    // chain links
    always_ff @(posedge aclk) begin
        if (links_we) begin
            links_mem[hp_reg[WIN_AW-1:0]] <= heads_q;
        end
        link_q <= links_mem[s_cand_reg[WIN_AW-1:0]];
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        size_next       = size_reg;
        cur_next        = cur_reg;
        hp_next         = hp_reg;
        b0_next         = b0_reg;
        b1_next         = b1_reg;
        h_next          = h_reg;
        clr_next        = clr_reg;
        s_pos_next      = s_pos_reg;
        s_lim_next      = s_lim_reg;
        s_best_next     = s_best_reg;
        s_dist_next     = s_dist_reg;
        s_left_next     = s_left_reg;
        s_cand_next     = s_cand_reg;
        s_l_next        = s_l_reg;
        m_best_next     = m_best_reg;
        m_dist_next     = m_dist_reg;
        indexed_next    = indexed_reg;
        k_next          = k_reg;
        pend_kind_next  = pend_kind_reg;
        pend_value_next = pend_value_reg;
        pend_dist_next  = pend_dist_reg;
        q_pop           = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == HASH_BITS'(HCOUNT - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    if (!q_data.is_end) begin
                        size_next = size_reg + 32'd1;
                        if (size_reg + 32'd1 - cur_reg >= LOOK32) begin
                            state_next = S_START;
                        end
                    end else if (cur_reg < size_reg) begin
                        state_next = S_START;
                    end else begin
                        pend_kind_next  = KIND_END;
                        pend_value_next = '0;
                        pend_dist_next  = '0;
                        state_next      = S_EMIT;
                    end
                end
            end
            S_START: begin
                if (avail >= MIN_LEN) begin
                    s_pos_next = cur_reg;
                    s_lim_next = limit;
                    hp_next    = cur_reg;
                    phase_next = P_SEARCH1;
                    state_next = S_HASH0;
                end else begin
                    state_next = S_LIT_RD;
                end
            end
            S_HASH0: begin
                state_next = S_HASH1;
            end
            S_HASH1: begin
                b0_next    = ring_qa;
                b1_next    = ring_qb;
                state_next = S_HASH2;
            end
            S_HASH2: begin
                h_next     = h_comb;
                state_next = S_HEAD;
            end
            S_HEAD: begin
                case (phase_reg)
                    P_SEARCH1, P_SEARCH2: begin
                        s_cand_next = heads_q;
                        s_left_next = max_chain;
                        s_best_next = '0;
                        s_dist_next = '0;
                        state_next  = ({23'd0, s_lim_reg} < MIN_LEN) ? S_SDONE : S_CAND;
                    end
                    P_IDX_LAZY: begin
                        s_pos_next = cur_reg + 32'd1;
                        s_lim_next = nlim;
                        hp_next    = cur_reg + 32'd1;
                        phase_next = P_SEARCH2;
                        state_next = S_HASH0;
                    end
                    P_IDX_LOOP: begin
                        k_next     = k_reg + 9'd1;
                        state_next = S_IXL;
                    end
                    default: begin
                        state_next = S_LIT_RD;
                    end
                endcase
            end
            S_CAND: begin
                if (s_cand_reg == EMPTY_MARK || s_left_reg == '0) begin
                    state_next = S_SDONE;
                end else begin
                    s_left_next = s_left_reg - 11'd1;
                    if (s_pos_reg <= s_cand_reg || cand_diff > WIN32) begin
                        state_next = S_SDONE;
                    end else begin
                        s_l_next   = '0;
                        state_next = S_CMP;
                    end
                end
            end
            S_CMP: begin
                if (cmp_eq && cmp_l1 < s_lim_reg) begin
                    s_l_next = cmp_l1;
                end else begin
                    s_l_next = fin_l;
                    if (fin_l > s_best_reg) begin
                        s_best_next = fin_l;
                        s_dist_next = cand_diff[15:0];
                        if (fin_l >= nice_match || fin_l >= s_lim_reg) begin
                            state_next = S_SDONE;
                        end else begin
                            state_next = S_LINK;
                        end
                    end else begin
                        state_next = S_LINK;
                    end
                end
            end
            S_LINK: begin
                s_cand_next = link_q;
                state_next  = S_CAND;
            end
            S_SDONE: begin
                if (phase_reg == P_SEARCH1) begin
                    m_best_next = fb;
                    m_dist_next = fd;
                    if ({23'd0, fb} >= MIN_LEN && fb < nice_match && avail >= 32'd4) begin
                        phase_next = P_IDX_LAZY;
                        hp_next    = cur_reg;
                        state_next = S_HASH0;
                    end else if ({23'd0, fb} >= MIN_LEN) begin
                        indexed_next = 1'b0;
                        k_next       = '0;
                        state_next   = S_IXL;
                    end else begin
                        phase_next = P_IDX_LIT;
                        hp_next    = cur_reg;
                        state_next = S_HASH0;
                    end
                end else begin
                    if (fb > m_best_reg) begin
                        state_next = S_LIT_RD;
                    end else begin
                        indexed_next = 1'b1;
                        k_next       = '0;
                        state_next   = S_IXL;
                    end
                end
            end
            S_IXL: begin
                if (k_reg >= m_best_reg) begin
                    pend_kind_next  = KIND_MATCH;
                    pend_value_next = m_best_reg;
                    pend_dist_next  = m_dist_reg;
                    cur_next        = cur_reg + {23'd0, m_best_reg};
                    state_next      = S_EMIT;
                end else if (k_reg == '0 && indexed_reg) begin
                    k_next = k_reg + 9'd1;
                end else if (size_reg - p_ix >= MIN_LEN) begin
                    phase_next = P_IDX_LOOP;
                    hp_next    = p_ix;
                    state_next = S_HASH0;
                end else begin
                    k_next = k_reg + 9'd1;
                end
            end
            S_LIT_RD: begin
                state_next = S_LIT;
            end
            S_LIT: begin
                pend_kind_next  = KIND_LITERAL;
                pend_value_next = {1'b0, ring_qa};
                pend_dist_next  = '0;
                cur_next        = cur_reg + 32'd1;
                state_next      = S_EMIT;
            end
            S_EMIT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            size_reg      <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            size_reg      <= size_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        phase_reg      <= phase_next;
        hp_reg         <= hp_next;
        b0_reg         <= b0_next;
        b1_reg         <= b1_next;
        h_reg          <= h_next;
        s_pos_reg      <= s_pos_next;
        s_lim_reg      <= s_lim_next;
        s_best_reg     <= s_best_next;
        s_dist_reg     <= s_dist_next;
        s_left_reg     <= s_left_next;
        s_cand_reg     <= s_cand_next;
        s_l_reg        <= s_l_next;
        m_best_reg     <= m_best_next;
        m_dist_reg     <= m_dist_next;
        indexed_reg    <= indexed_next;
        k_reg          <= k_next;
        pend_kind_reg  <= pend_kind_next;
        pend_value_reg <= pend_value_next;
        pend_dist_reg  <= pend_dist_next;
        if (out_load) begin
            out_kind_reg  <= pend_kind_reg;
            out_value_reg <= pend_value_reg;
            out_dist_reg  <= pend_dist_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {7'd0, out_dist_reg, out_value_reg};

    // checks
    a_cur_within_size: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_reg <= size_reg) else $error("coded position passed received bytes");

    a_match_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_MATCH) |->
        ({23'd0, out_value_reg} >= MIN_LEN && out_dist_reg != '0
         && {16'd0, out_dist_reg} <= WIN32))
        else $error("match token out of range");

    a_no_output_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !m_tvalid) else $error("result during clear pass");

    a_cmp_within_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP) |-> (s_l_reg < s_lim_reg))
        else $error("compare ran past its limit");

endmodule

/* tb/lzhc_token_checker.sv */
// ----------------------------------------------------------------------------
// lzhc_token_checker
// Watches the byte and token streams of the LZ77 matcher and keeps its own
// copy of the history ring, hash heads and chain links. Every accepted input
// beat is run through the token predictor. Every token beat is compared
// field by field with the oldest predicted token.
// ----------------------------------------------------------------------------
module lzhc_token_checker
    import lzhc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [7:0]       s_tdata,    // [7:0] data_byte
    input  logic             s_tuser,    // [0] op
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [31:0]      m_tdata,    // [8:0] value, [24:9] distance
    input  logic [1:0]       m_tuser,    // [1:0] kind
    input  logic             cfg_we,
    input  logic             cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    output int               n_pending,
    output int               n_fail
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN     = 32768;
    localparam int HASH_N  = 32768;
    localparam int MAX_LEN = 258;
    localparam int LOOK    = 262;

    typedef struct {
        logic [1:0]  kind;
        logic [8:0]  value;
        logic [15:0] distance;
    } token_t;

    logic [7:0]  hist_mem [0:65535];
    logic [31:0] head_tab [0:HASH_N-1];
    logic [31:0] link_tab [0:WIN-1];
    logic [31:0] n_bytes;
    logic [31:0] code_pos;
    logic        ended;
    logic [31:0] chain_max;
    logic [31:0] nice_len;

    token_t tok_q [$];

    function automatic logic [31:0] byte_at(input logic [31:0] p);
        return {24'd0, hist_mem[p[15:0]]};
    endfunction

    function automatic logic [14:0] hash_of(input logic [31:0] p);
        logic [31:0] h;
        h = (byte_at(p) << 10) ^ (byte_at(p + 1) << 5) ^ byte_at(p + 2);
        return h[14:0];
    endfunction

    function automatic void insert_pos(input logic [31:0] p);
        logic [14:0] h;
        h = hash_of(p);
        link_tab[p[14:0]] = head_tab[h];
        head_tab[h] = p;
    endfunction

    // longest earlier match at pos, walking at most chain_max candidates
    function automatic void match_search(input logic [31:0] pos, input logic [31:0] limit,
                                         output logic [31:0] blen,
                                         output logic [31:0] bdist);
        logic [31:0] best, best_dist, cand, left, c, l;
        best = 0;
        best_dist = 0;
        blen = 0;
        bdist = 0;
        if (limit < 3) return;
        cand = head_tab[hash_of(pos)];
        left = chain_max;
        while (cand != EMPTY_MARK && left > 0) begin
            c = cand;
            left = left - 1;
            if (pos <= c || pos - c > WIN) break;
            if (best == 0 || byte_at(c + best) == byte_at(pos + best)) begin
                l = 0;
                while (l < limit && byte_at(c + l) == byte_at(pos + l)) l = l + 1;
                if (l > best) begin
                    best = l;
                    best_dist = pos - c;
                    if (l >= nice_len || l >= limit) break;
                end
            end
            cand = link_tab[c[14:0]];
        end
        if (best >= 3) begin
            blen = best;
            bdist = best_dist;
        end
    endfunction

    // decide the token at the coding position, with size bytes known
    function automatic token_t next_token(input logic [31:0] size);
        token_t t;
        logic [31:0] pos, avail, limit, best, best_dist, nlen, ndist, nlim, p;
        logic indexed, lazy_lit;
        pos = code_pos;
        avail = size - pos;
        limit = (avail < MAX_LEN) ? avail : MAX_LEN;
        best = 0;
        best_dist = 0;
        indexed = 1'b0;
        lazy_lit = 1'b0;
        if (avail >= 3) begin
            match_search(pos, limit, best, best_dist);
            if (best >= 3 && best < nice_len && avail >= 4) begin
                nlim = (avail - 1 < MAX_LEN) ? avail - 1 : MAX_LEN;
                insert_pos(pos);
                indexed = 1'b1;
                match_search(pos + 1, nlim, nlen, ndist);
                // a longer match one byte on: emit the current byte as literal
                if (nlen > best) lazy_lit = 1'b1;
            end
        end
        if (!lazy_lit && best >= 3) begin
            for (p = pos; p < pos + best; p++) begin
                if (!(p == pos && indexed) && size - p >= 3) insert_pos(p);
            end
            t.kind = KIND_MATCH;
            t.value = best[8:0];
            t.distance = best_dist[15:0];
            code_pos = pos + best;
        end else begin
            if (!lazy_lit && !indexed && avail >= 3) insert_pos(pos);
            t.kind = KIND_LITERAL;
            t.value = 9'(byte_at(pos));
            t.distance = 16'd0;
            code_pos = pos + 1;
        end
        return t;
    endfunction

    task automatic report(input string field, input int got, input int want);
        $display("mismatch %0s: got %0d expected %0d", field, got, want);
        n_fail = n_fail + 1;
    endtask

    initial begin
        n_fail = 0;
        n_pending = 0;
        for (int i = 0; i < HASH_N; i++) head_tab[i] = EMPTY_MARK;
    end

    // track beats on every channel
    always @(posedge aclk) begin
        token_t t, e;
        if (!aresetn) begin
            n_bytes   = 0;
            code_pos  = 0;
            ended     = 1'b0;
            chain_max = 32'(MAX_CHAIN_RST);
            nice_len  = 32'(NICE_MATCH_RST);
        end else begin
            // compare an outgoing token beat
            if (m_tvalid && m_tready) begin
                if (tok_q.size() == 0) begin
                    $display("token beat with no token predicted");
                    n_fail = n_fail + 1;
                end else begin
                    e = tok_q.pop_front();
                    if (m_tuser !== e.kind) report("kind", m_tuser, e.kind);
                    if (m_tdata[8:0] !== e.value) report("value", m_tdata[8:0], e.value);
                    if (m_tdata[24:9] !== e.distance)
                        report("distance", m_tdata[24:9], e.distance);
                end
            end
            if (cfg_we) begin
                if (cfg_addr == REG_MAX_CHAIN) chain_max = 32'(cfg_wdata);
                else nice_len = 32'(cfg_wdata[NICE_MATCH_W-1:0]);
            end
            // predict from an incoming beat
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_DATA) begin
                    if (!ended && n_bytes < BYTES_LIMIT) begin
                        hist_mem[n_bytes[15:0]] = s_tdata;
                        n_bytes = n_bytes + 1;
                        if (n_bytes - code_pos >= LOOK)
                            tok_q.insert(tok_q.size(), next_token(n_bytes));
                    end
                end else begin
                    ended = 1'b1;
                    if (code_pos < n_bytes) begin
                        tok_q.insert(tok_q.size(), next_token(n_bytes));
                    end else begin
                        t.kind = KIND_END;
                        t.value = 9'd0;
                        t.distance = 16'd0;
                        tok_q.insert(tok_q.size(), t);
                    end
                end
            end
        end
        n_pending <= tok_q.size();
    end

endmodule

/* tb/tb_lz77_hash_chain_lazy_matcher_top.sv */
// ----------------------------------------------------------------------------
// tb_lz77_hash_chain_lazy_matcher_top
// Drives one byte stream through the LZ77 matcher in phases, each with its own
// register setting and idle pattern, then drains it with end beats. The token
// checker predicts and compares; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module tb_lz77_hash_chain_lazy_matcher_top;
    import lzhc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 6000000;
    localparam int SETTLE      = 3000;
    localparam int PHASE_BYTES = 150;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic             s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [31:0]      m_tdata;
    logic [1:0]       m_tuser;
    logic             cfg_we;
    logic             cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;
    int               n_pending;
    int               n_fail;

    int          idle_pct;
    int          stall_pct;
    int          n_cycles;
    logic [7:0]  sent [0:4095];
    int          n_sent;

    lz77_hash_chain_lazy_matcher_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    lzhc_token_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .n_pending(n_pending), .n_fail(n_fail)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // token receiver with random stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // run watchdog
    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // one input beat, with a random gap in front
    task automatic send_beat(input logic op, input logic [7:0] b);
        if ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == OP_DATA && n_sent < 4096) begin
            sent[n_sent] = b;
            n_sent++;
        end
    endtask

    // hold off until every predicted token is out, then let the engine settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_regs(input int chain, input int nice);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_MAX_CHAIN;
        cfg_wdata <= CFG_W'(chain);
        @(posedge aclk);
        cfg_addr  <= REG_NICE_MATCH;
        cfg_wdata <= CFG_W'(nice);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    // one random chunk of the byte stream
    task automatic send_chunk();
        int mode, len, offset, base;
        logic [7:0] b;
        mode = $urandom_range(9);
        if (mode < 2) begin
            // noise
            len = $urandom_range(20, 1);
            repeat (len) send_beat(OP_DATA, 8'($urandom));
        end else if (mode < 4) begin
            // run of one byte, now and then longer than a match can be
            len = ($urandom_range(9) == 0) ? $urandom_range(300, 200) : $urandom_range(40, 3);
            b = 8'($urandom);
            repeat (len) send_beat(OP_DATA, b);
        end else if (mode < 7 && n_sent > 4) begin
            // copy of earlier stream content
            offset = $urandom_range(n_sent, 1);
            len = ($urandom_range(9) == 0) ? $urandom_range(270, 100) : $urandom_range(60, 3);
            base = n_sent - offset;
            for (int i = 0; i < len; i++) send_beat(OP_DATA, sent[base + i]);
        end else begin
            // small alphabet
            len = $urandom_range(30, 4);
            base = $urandom_range(255);
            repeat (len) send_beat(OP_DATA, 8'(base + $urandom_range(2)));
        end
    endtask

    initial begin
        logic [7:0] directed [0:19];
        int chain_set [0:7];
        int nice_set  [0:7];
        int start;
        directed = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hAA, 8'h55, 8'h00,
                     8'hFF, 8'h01, 8'h80, 8'h61, 8'h62, 8'h63, 8'h61, 8'h62,
                     8'h63, 8'h61, 8'h62, 8'h64};
        chain_set = '{160, 1024, 1, 0, 2047, 8, 64, 300};
        nice_set  = '{128, 258, 3, 2, 511, 0, 1, 40};
        n_cycles  = 0;
        n_sent    = 0;
        idle_pct  = 0;
        stall_pct = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        s_tuser   <= OP_DATA;
        m_tready  <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= REG_MAX_CHAIN;
        cfg_wdata <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // byte stream in phases, one register setting and idle pattern each
        for (int ph = 0; ph < 8; ph++) begin
            set_regs(chain_set[ph], nice_set[ph]);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 77; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 77; end
                default: begin idle_pct = 34; stall_pct = 34; end
            endcase
            if (ph == 0) begin
                foreach (directed[i]) send_beat(OP_DATA, directed[i]);
            end
            start = n_sent;
            while (n_sent - start < PHASE_BYTES) send_chunk();
            wait_drained();
        end

        // drain past the last pending token, then data after end is ignored
        idle_pct = 34;
        stall_pct = 34;
        repeat (280) send_beat(OP_END, 8'($urandom));
        repeat (5) send_beat(OP_DATA, 8'($urandom));
        repeat (5) send_beat(OP_END, 8'hFF);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        if (n_fail == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* lz77_hash_chain_lazy_matcher_top.f */
design/lzhc_pkg.sv
design/lzhc_queue.sv
design/lzhc_front.sv
design/lzhc_back.sv
design/lz77_hash_chain_lazy_matcher_top.sv
tb/lzhc_token_checker.sv
tb/tb_lz77_hash_chain_lazy_matcher_top.sv
